/* rtl/rhps_pkg.sv */
// Shared types and constants of the rolling hash pattern search core.
`timescale 1ns / 1ps

package rhps_pkg;

	// Field and register widths fixed by the interface.
	localparam int unsigned LEN_W      = 5;
	localparam int unsigned TEXT_W     = 8;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned PAT_BYTES  = 16;
	localparam int unsigned PIDX_W     = 4;

	// Modular arithmetic: residues are 30 bits, products before reduction 39 bits.
	localparam int unsigned RES_W  = 30;
	localparam int unsigned PROD_W = 39;
	localparam int unsigned QA_W   = 10;
	localparam int unsigned MU_W   = 11;
	localparam int unsigned QM_W   = QA_W + MU_W;
	localparam int unsigned BASE_W = 9;

	localparam logic [RES_W-1:0]  HASH_MOD   = 30'd1000000007;
	localparam logic [BASE_W-1:0] HASH_BASE  = 9'd263;
	// floor(2^40 / HASH_MOD), used to estimate the quotient from the top product bits.
	localparam logic [MU_W-1:0]   BARRETT_MU = 11'd1099;
	localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_PATTERN_LOW    = 2'd1,
		REG_PATTERN_HIGH   = 2'd2
	} cfg_reg_t;

	// Operation carried out by one load, multiply and fold pass of the datapath.
	typedef enum logic [1:0] {
		OP_PHASH = 2'd0,
		OP_TPOW  = 2'd1,
		OP_SUB   = 2'd2,
		OP_ROLL  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_LOAD  = 3'd1,
		ST_MULT  = 3'd2,
		ST_FOLD  = 3'd3,
		ST_CHECK = 3'd4
	} state_t;

	typedef struct packed {
		logic             accept;
		logic             load;
		logic             fold;
		logic             emit;
		op_t              op;
		logic [LEN_W-1:0] iter;
	} dp_cmd_t;

	typedef struct packed {
		logic [LEN_W-1:0] eff_len;
		logic             hit;
		logic             out_free;
	} dp_sts_t;

endpackage

/* rtl/rolling_hash_pattern_search_core.sv */
// Top level of the rolling hash pattern search core.
`timescale 1ns / 1ps

// An ordinary item runs two reduction passes, then a match check that registers a result on a hit.
// An item that starts a new text first rebuilds the pattern hash and top power: 2L-1
// more reduction passes, where L is the effective pattern length.
// No new item is taken until the last one is through the shared modular reducer and its check.
// Reset (asynchronous, active low) gives length 1, zero pattern, empty window, position zero.

module rolling_hash_pattern_search_core import rhps_pkg::*; #(
	parameter int unsigned MAX_PATTERN_LENGTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TEXT_W-1:0]     text_char,
	input  logic                  first_of_text,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_W-1:0]      match_start,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// The controller sequences each item as a series of reduction passes. Each pass
	// loads a product into the datapath, multiplies its top bits by a reciprocal of
	// the modulus, and folds the estimate back into a residue. An ordinary item needs
	// two passes: the outgoing byte times the top power, then the rolled hash times
	// the base plus the new byte. A new text first runs L passes for the pattern hash
	// and L-1 for the top power.

	dp_cmd_t cmd;
	dp_sts_t sts;

	rhps_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.first_of_text (first_of_text),
		.in_ready      (in_ready),
		.sts           (sts),
		.cmd           (cmd)
	);

	// The datapath holds the configuration registers, the byte window, the hashes,
	// the position counter and the output register. The output register lets a new
	// item be taken while the previous result still waits on out_ready.
	rhps_datapath #(
		.MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_char     (text_char),
		.first_of_text (first_of_text),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match_start   (match_start),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

/* rtl/rhps_datapath.sv */
// Datapath of the rolling hash pattern search core: registers, window, modular reducer.
`timescale 1ns / 1ps

module rhps_datapath import rhps_pkg::*; #(
	parameter int unsigned MAX_PATTERN_LENGTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [TEXT_W-1:0]     text_char,
	input  logic                  first_of_text,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_W-1:0]      match_start,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts
);

	localparam int unsigned WIN_IDX_W = (MAX_PATTERN_LENGTH > 1) ? $clog2(MAX_PATTERN_LENGTH) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_LENGTH);
	localparam int unsigned PW1   = PROD_W + 1;
	localparam int unsigned POSW1 = POS_W + 1;

	function automatic logic [TEXT_W-1:0] pat_byte(input logic [8*PAT_BYTES-1:0] v,
		input logic [PIDX_W-1:0] i);
		return v[i*TEXT_W +: TEXT_W];
	endfunction

	logic [LEN_W-1:0]       plen_q;
	logic [CFG_DATA_W-1:0]  pat_lo_q;
	logic [CFG_DATA_W-1:0]  pat_hi_q;
	logic [TEXT_W-1:0]      win_q [MAX_PATTERN_LENGTH];
	logic [RES_W-1:0]       whash_q;
	logic [RES_W-1:0]       phash_q;
	logic [RES_W-1:0]       tpow_q;
	logic [RES_W-1:0]       sub_q;
	logic [POS_W-1:0]       seen_q;
	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       match_q;
	logic                   out_valid_q;
	logic [TEXT_W-1:0]      chr_q;
	logic [PROD_W-1:0]      x_q;
	logic [QM_W-1:0]        qm_q;

	logic [8*PAT_BYTES-1:0] pat_vec;
	logic [LEN_W-1:0]       eff_len;
	logic [LEN_W-1:0]       len_m1;
	logic [TEXT_W-1:0]      outgoing;
	logic [RES_W:0]         h_sum;
	logic [RES_W-1:0]       h0;
	logic [PROD_W-1:0]      x_d;
	logic [QA_W-1:0]        q_est;
	logic [PW1-1:0]         qprod;
	logic [PW1-1:0]         diff;
	logic [RES_W:0]         r_raw;
	logic [RES_W-1:0]       red;
	logic                   eq_all;
	logic                   len_ok;

	assign cfg_ready = 1'b1;
	assign pat_vec   = {pat_hi_q, pat_lo_q};

	// Out-of-range lengths clamp to the supported span.
	always_comb begin
		eff_len = plen_q;
		if (plen_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (plen_q > MAX_LEN) begin
			eff_len = MAX_LEN;
		end
	end

	assign len_m1   = eff_len - LEN_W'(1);
	assign outgoing = win_q[len_m1[WIN_IDX_W-1:0]];

	// Window hash minus the outgoing term, brought back below the modulus.
	assign h_sum = {1'b0, whash_q} + {1'b0, HASH_MOD} - {1'b0, sub_q};
	assign h0    = (h_sum >= {1'b0, HASH_MOD}) ? RES_W'(h_sum - {1'b0, HASH_MOD})
		: h_sum[RES_W-1:0];

	always_comb begin
		unique case (cmd.op)
			OP_PHASH: x_d = PROD_W'(phash_q) * PROD_W'(HASH_BASE)
				+ PROD_W'(pat_byte(pat_vec, cmd.iter[PIDX_W-1:0]));
			OP_TPOW:  x_d = PROD_W'(tpow_q) * PROD_W'(HASH_BASE);
			OP_SUB:   x_d = PROD_W'(outgoing) * PROD_W'(tpow_q);
			OP_ROLL:  x_d = PROD_W'(h0) * PROD_W'(HASH_BASE) + PROD_W'(chr_q);
			default:  x_d = '0;
		endcase
	end

	// Quotient estimate from the top ten product bits; it is low by at most one,
	// so a single conditional subtract finishes the reduction.
	assign q_est = qm_q[QM_W-1 -: QA_W];
	assign qprod = PW1'(q_est) * PW1'(HASH_MOD);
	assign diff  = {1'b0, x_q} - qprod;
	assign r_raw = diff[RES_W:0];
	assign red   = (r_raw >= {1'b0, HASH_MOD}) ? RES_W'(r_raw - {1'b0, HASH_MOD})
		: r_raw[RES_W-1:0];

	always_comb begin
		logic [LEN_W-1:0] pidx;
		eq_all = 1'b1;
		for (int k = 0; k < MAX_PATTERN_LENGTH; k++) begin
			pidx = len_m1 - LEN_W'(k);
			if ((LEN_W'(k) < eff_len)
				&& (win_q[k] != pat_byte(pat_vec, pidx[PIDX_W-1:0]))) begin
				eq_all = 1'b0;
			end
		end
	end

	assign len_ok = ({1'b0, pos_q} + POSW1'(1)) >= POSW1'(eff_len);

	assign sts.eff_len  = eff_len;
	assign sts.hit      = len_ok && (whash_q == phash_q) && eq_all;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= LEN_W'(1);
			pat_lo_q <= '0;
			pat_hi_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LENGTH: plen_q   <= cfg_data[LEN_W-1:0];
				REG_PATTERN_LOW:    pat_lo_q <= cfg_data;
				REG_PATTERN_HIGH:   pat_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN_LENGTH; k++) begin
				win_q[k] <= '0;
			end
			whash_q     <= '0;
			phash_q     <= '0;
			tpow_q      <= RES_W'(1);
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && first_of_text) begin
				for (int k = 0; k < MAX_PATTERN_LENGTH; k++) begin
					win_q[k] <= '0;
				end
				whash_q <= '0;
				phash_q <= '0;
				tpow_q  <= RES_W'(1);
				seen_q  <= '0;
			end
			if (cmd.fold) begin
				unique case (cmd.op)
					OP_PHASH: phash_q <= red;
					OP_TPOW:  tpow_q  <= red;
					OP_SUB: ;
					OP_ROLL: begin
						whash_q <= red;
						for (int k = 1; k < MAX_PATTERN_LENGTH; k++) begin
							win_q[k] <= win_q[k-1];
						end
						win_q[0] <= chr_q;
						if (seen_q != POS_MAX) begin
							seen_q <= seen_q + POS_W'(1);
						end
					end
					default: ;
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		qm_q <= QM_W'(x_q[PROD_W-1 -: QA_W]) * QM_W'(BARRETT_MU);
		if (cmd.accept) begin
			chr_q <= text_char;
		end
		if (cmd.load) begin
			x_q <= x_d;
		end
		if (cmd.fold && (cmd.op == OP_SUB)) begin
			sub_q <= red;
		end
		if (cmd.fold && (cmd.op == OP_ROLL)) begin
			pos_q <= seen_q;
		end
		if (cmd.emit) begin
			match_q <= pos_q + POS_W'(1) - POS_W'(eff_len);
		end
	end

	assign out_valid   = out_valid_q;
	assign match_start = match_q;

	a_whash_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		whash_q < HASH_MOD)
		else $error("window hash left the residue range");

	a_setup_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(phash_q < HASH_MOD) && (tpow_q < HASH_MOD))
		else $error("pattern hash or top power left the residue range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result loaded over one still waiting");

endmodule

/* rtl/rhps_ctrl.sv */
// Controller state machine of the rolling hash pattern search core.
`timescale 1ns / 1ps

module rhps_ctrl import rhps_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    first_of_text,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t           state_q, state_d;
	op_t              op_q, op_d;
	logic [LEN_W-1:0] iter_q, iter_d;
	logic [LEN_W-1:0] iter_nx;

	assign iter_nx = iter_q + LEN_W'(1);

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		iter_d  = iter_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOAD;
					iter_d  = '0;
					op_d    = first_of_text ? OP_PHASH : OP_SUB;
				end
			end
			ST_LOAD: state_d = ST_MULT;
			ST_MULT: state_d = ST_FOLD;
			ST_FOLD: begin
				state_d = ST_LOAD;
				unique case (op_q)
					OP_PHASH: begin
						if (iter_nx == sts.eff_len) begin
							op_d = OP_SUB;
						end else begin
							op_d = OP_TPOW;
						end
					end
					OP_TPOW: begin
						if (iter_nx == sts.eff_len) begin
							op_d = OP_SUB;
						end else begin
							op_d   = OP_PHASH;
							iter_d = iter_nx;
						end
					end
					OP_SUB:  op_d = OP_ROLL;
					OP_ROLL: state_d = ST_CHECK;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_CHECK: begin
				if (!sts.hit || sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.op     = op_q;
		cmd.iter   = iter_q;
		in_ready   = (state_q == ST_IDLE);
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.load   = (state_q == ST_LOAD);
		cmd.fold   = (state_q == ST_FOLD);
		cmd.emit   = (state_q == ST_CHECK) && sts.hit && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SUB;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			iter_q  <= iter_d;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_LOAD))
		else $error("accepted item did not start a reduction pass");

	a_roll_checks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fold && (op_q == OP_ROLL)) |=> (state_q == ST_CHECK))
		else $error("hash roll not followed by the match check");

	a_miss_returns: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CHECK) && !sts.hit) |=> (state_q == ST_IDLE))
		else $error("check without a hit did not return to idle");

endmodule

/* dv/tb.sv */
// Testbench for the rolling hash pattern search core: directed table, then random texts.
`timescale 1ns / 1ps

module tb;
	import rhps_pkg::*;

	// Half the clock period and the number of cycles that reset is held.
	localparam int unsigned HALF_PERIOD = 6;
	localparam int unsigned RESET_CYCLES = 8;
	// An item that starts a new text also rebuilds the pattern hash and top power first.
	// Waiting QUIET_CYCLES after the last result leaves the core idle.
	localparam int unsigned QUIET_CYCLES = 128;
	// Cycles without any accepted item on any channel before the run is declared hung.
	localparam int unsigned HANG_LIMIT = 4000;
	localparam int unsigned PHASES = 20;
	localparam int unsigned ITEMS_PER_PHASE = 100;
	// Index 3 names no register; the core must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
	localparam bit [63:0] MOD64 = 64'(HASH_MOD);

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	// How a directed row gets its expectation: from the predictor, typed in the table, or none.
	typedef enum logic [1:0] {
		EXP_PREDICT,
		EXP_NONE,
		EXP_AT
	} exp_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
		logic [TEXT_W-1:0]     ch;
		logic                  first;
		exp_kind_t             exp;
		logic [POS_W-1:0]      exp_pos;
	} dir_row_t;

	localparam int unsigned DIR_ROWS = 25;

	// Directed table. It opens on the reset state (length 1, pattern byte zero, no new-text
	// item yet), then covers the length extremes, all-ones pattern bytes, an overlapping
	// three-byte pattern, the sparse register index and a length change in the middle of a text.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, EXP_AT, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h01, 1'b0, EXP_NONE, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, EXP_AT, 32'd2},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, EXP_NONE, 32'd0},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE0, 8'h00, 1'b0, EXP_NONE, 32'd0},
		'{ROW_CFG, REG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, EXP_NONE, 32'd0},
		'{ROW_CFG, REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, EXP_NONE, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b1, EXP_AT, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'hFF, 1'b0, EXP_AT, 32'd1},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h7F, 1'b0, EXP_NONE, 32'd0},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'h0000_0000_0000_0003, 8'h00, 1'b0, EXP_NONE, 32'd0},
		'{ROW_CFG, REG_PATTERN_LOW, 64'h0000_0000_0041_4241, 8'h00, 1'b0, EXP_NONE, 32'd0},
		'{ROW_CFG, CFG_IDX_SPARE, 64'h5A5A_A5A5_0F0F_F0F0, 8'h00, 1'b0, EXP_NONE, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h41, 1'b1, EXP_NONE, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h42, 1'b0, EXP_NONE, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h41, 1'b0, EXP_AT, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h42, 1'b0, EXP_NONE, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h41, 1'b0, EXP_AT, 32'd2},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'h0000_0000_0000_001F, 8'h00, 1'b0, EXP_NONE, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h41, 1'b0, EXP_PREDICT, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h42, 1'b0, EXP_PREDICT, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h41, 1'b1, EXP_PREDICT, 32'd0},
		'{ROW_CFG, REG_PATTERN_LENGTH, 64'h0000_0000_0000_0010, 8'h00, 1'b0, EXP_NONE, 32'd0},
		'{ROW_CFG, REG_PATTERN_HIGH, 64'h0, 8'h00, 1'b0, EXP_NONE, 32'd0},
		'{ROW_ITEM, REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b1, EXP_PREDICT, 32'd0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [TEXT_W-1:0]     text_char = '0;
	logic                  first_of_text = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [POS_W-1:0]      match_start;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the search state and registers, at their reset values.
	logic [TEXT_W-1:0]     win_bytes [PAT_BYTES] = '{default: 8'h00};
	logic [RES_W-1:0]      roll_hash = '0;
	logic [RES_W-1:0]      pat_hash = '0;
	logic [RES_W-1:0]      lead_power = 30'd1;
	logic [POS_W-1:0]      text_pos = '0;
	logic [LEN_W-1:0]      cfg_len = 5'd1;
	logic [CFG_DATA_W-1:0] cfg_lo = '0;
	logic [CFG_DATA_W-1:0] cfg_hi = '0;

	// Start positions still owed by the core, oldest first.
	logic [POS_W-1:0] pending_starts [$];
	logic [POS_W-1:0] owed_start;
	int unsigned      error_count = 0;
	int unsigned      idle_cycles = 0;
	// While set, neither side inserts gaps or stalls.
	bit               steady = 1'b0;

	rolling_hash_pattern_search_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_char     (text_char),
		.first_of_text (first_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match_start   (match_start),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	task automatic flag_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		error_count++;
	endtask

	// Appends one start position at the tail of the owed list.
	task automatic owe_start(input logic [POS_W-1:0] p);
		pending_starts.insert(pending_starts.size(), p);
	endtask

	function automatic bit take_gap();
		return !steady && ($urandom_range(99) < 36);
	endfunction

	// Effective pattern length: zero acts as one, anything above the maximum as the maximum.
	function automatic int unsigned eff_len();
		int unsigned l;
		l = cfg_len;
		if (l == 0)
			l = 1;
		if (l > PAT_BYTES)
			l = PAT_BYTES;
		return l;
	endfunction

	function automatic logic [TEXT_W-1:0] pat_byte(input int unsigned i);
		logic [CFG_DATA_W-1:0] word;
		word = (i < 8) ? cfg_lo : cfg_hi;
		return word[(i % 8) * 8 +: 8];
	endfunction

	// A new text rebuilds the pattern hash and the power of the oldest byte from the
	// registers as they stand, and clears the window, its hash and the position.
	task automatic begin_text();
		bit [63:0]   h;
		bit [63:0]   p;
		int unsigned len;
		len = eff_len();
		h = 0;
		p = 1;
		for (int unsigned i = 0; i < len; i++)
			h = (h * 64'(HASH_BASE) + 64'(pat_byte(i))) % MOD64;
		for (int unsigned i = 1; i < len; i++)
			p = (p * 64'(HASH_BASE)) % MOD64;
		pat_hash = h[RES_W-1:0];
		lead_power = p[RES_W-1:0];
		roll_hash = '0;
		text_pos = '0;
		foreach (win_bytes[k])
			win_bytes[k] = '0;
	endtask

	// Shifts one text byte into the shadow window and tells whether a full match ends on it.
	// The byte comparison always reads the live registers, while the pattern hash and the
	// top power wait for the next new text, so a mid-text register change can hide matches.
	task automatic search_step(input logic [TEXT_W-1:0] ch, input logic first,
			output bit hit, output logic [POS_W-1:0] start);
		int unsigned len;
		bit [63:0]   sub;
		bit [63:0]   h;
		bit [63:0]   pos;
		bit          same;
		if (first)
			begin_text();
		len = eff_len();
		sub = (64'(win_bytes[len - 1]) * 64'(lead_power)) % MOD64;
		h = (64'(roll_hash) + MOD64 - sub) % MOD64;
		h = (h * 64'(HASH_BASE) + 64'(ch)) % MOD64;
		roll_hash = h[RES_W-1:0];
		for (int k = PAT_BYTES - 1; k > 0; k--)
			win_bytes[k] = win_bytes[k - 1];
		win_bytes[0] = ch;
		pos = 64'(text_pos);
		if (text_pos != POS_MAX)
			text_pos = text_pos + 1;
		hit = 1'b0;
		start = '0;
		if (pos + 1 >= 64'(len) && roll_hash == pat_hash) begin
			same = 1'b1;
			for (int unsigned k = 0; k < len; k++)
				if (win_bytes[k] != pat_byte(len - 1 - k))
					same = 1'b0;
			if (same) begin
				hit = 1'b1;
				start = POS_W'(pos + 1 - 64'(len));
			end
		end
	endtask

	// Offers one text item, holds it until taken, then records what it should produce.
	task automatic send_item(input logic [TEXT_W-1:0] ch, input logic first,
			input exp_kind_t how, input logic [POS_W-1:0] typed_pos);
		bit               hit;
		logic [POS_W-1:0] start;
		@(negedge clk);
		while (take_gap()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_char <= ch;
		first_of_text <= first;
		do
			@(posedge clk);
		while (!in_ready);
		search_step(ch, first, hit, start);
		case (how)
			EXP_PREDICT: begin
				if (hit)
					owe_start(start);
			end
			EXP_AT: owe_start(typed_pos);
			default: ;
		endcase
	endtask

	// Drops valid, waits for every owed result, then lets the core finish any result-less work.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_starts.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		while (take_gap())
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_PATTERN_LENGTH: cfg_len = data[LEN_W-1:0];
			REG_PATTERN_LOW:    cfg_lo = data;
			REG_PATTERN_HIGH:   cfg_hi = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// The receiver stalls at random except in steady stretches.
	always @(negedge clk)
		out_ready <= steady || ($urandom_range(99) >= 36);

	// Every accepted result must be the oldest start position still owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_starts.size() == 0) begin
				flag_mismatch($sformatf("match_start %0d with no match owed", match_start));
			end else begin
				owed_start = pending_starts.pop_front();
				if (match_start !== owed_start)
					flag_mismatch($sformatf("match_start %0d, expected %0d",
						match_start, owed_start));
			end
		end
	end

	// Hang guard: any accepted item on any channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [TEXT_W-1:0]     pat [PAT_BYTES];
		logic [TEXT_W-1:0]     abc [4];
		logic [CFG_DATA_W-1:0] word;
		logic [TEXT_W-1:0]     ch;
		int unsigned           sent;
		int unsigned           el;
		int unsigned           len_val;
		int unsigned           style;
		int unsigned           bad_at;
		bit                    item_open;
		bit                    new_text;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Configuration rows wait for the core to go quiet first.
		item_open = 1'b0;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				if (item_open)
					settle();
				item_open = 1'b0;
				cfg_write(dir_rows[r].reg_idx, dir_rows[r].reg_data);
			end else begin
				send_item(dir_rows[r].ch, dir_rows[r].first, dir_rows[r].exp,
					dir_rows[r].exp_pos);
				item_open = 1'b1;
			end
		end

		// Random part: each phase sets a pattern and streams text seeded with copies of it,
		// some of them with one bit flipped, over a small alphabet so near misses are common.
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			settle();
			steady = (ph >= 8 && ph < 11);

			case ($urandom_range(9))
				0: len_val = 0;
				1: len_val = 1;
				2: len_val = PAT_BYTES;
				3: len_val = $urandom_range(31, 17);
				default: len_val = $urandom_range(8, 2);
			endcase
			el = (len_val == 0) ? 1 : ((len_val > PAT_BYTES) ? PAT_BYTES : len_val);

			abc[0] = 8'($urandom);
			abc[1] = 8'($urandom);
			abc[2] = 8'h00;
			abc[3] = 8'hFF;
			style = $urandom_range(3);
			foreach (pat[i]) begin
				case (style)
					0: pat[i] = 8'($urandom);
					1: pat[i] = abc[$urandom_range(1)];
					2: pat[i] = abc[0];
					default: pat[i] = abc[$urandom_range(3)];
				endcase
			end

			// Now and then a pattern register is left as it was from the phase before.
			if ($urandom_range(4) != 0) begin
				for (int unsigned i = 0; i < 8; i++)
					word[i * 8 +: 8] = pat[i];
				cfg_write(REG_PATTERN_LOW, word);
			end
			if ($urandom_range(4) != 0) begin
				for (int unsigned i = 0; i < 8; i++)
					word[i * 8 +: 8] = pat[8 + i];
				cfg_write(REG_PATTERN_HIGH, word);
			end
			if ($urandom_range(9) == 0)
				cfg_write(CFG_IDX_SPARE, {$urandom, $urandom});
			word = {$urandom, $urandom};
			word[LEN_W-1:0] = LEN_W'(len_val);
			cfg_write(REG_PATTERN_LENGTH, word);

			// Most phases open a fresh text; the rest carry on with the stale hash state.
			new_text = ($urandom_range(4) != 0);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(99) < 35) begin
					bad_at = ($urandom_range(9) == 0) ? $urandom_range(el - 1) : PAT_BYTES;
					for (int unsigned i = 0; i < el; i++) begin
						ch = pat[i];
						if (i == bad_at)
							ch = ch ^ (8'h01 << $urandom_range(7));
						send_item(ch, new_text || ($urandom_range(99) < 2), EXP_PREDICT, '0);
						new_text = 1'b0;
						sent++;
					end
				end else begin
					ch = ($urandom_range(9) < 7) ? abc[$urandom_range(3)] : 8'($urandom);
					send_item(ch, new_text || ($urandom_range(99) < 3), EXP_PREDICT, '0);
					new_text = 1'b0;
					sent++;
				end
			end
		end

		steady = 1'b0;
		settle();
		if (pending_starts.size() != 0)
			flag_mismatch($sformatf("%0d matches never reported", pending_starts.size()));
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
